@@ hdl/wav_pcm16_stream_decoder_core_defines.svh @@
// Assertion macros for the PCM16 stream decoder.
// Included by modules that carry concurrent checks.
`ifndef WAV_PCM16_STREAM_DECODER_CORE_DEFINES_SVH
`define WAV_PCM16_STREAM_DECODER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define WPD_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("wpd check");
`define WPD_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("wpd check");
`else
`define WPD_ASSERT_IMPL(label, clk, rst, a, c)
`define WPD_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

@@ hdl/wpd_pkg.sv @@
// Package for the PCM16 stream decoder: codes and payload types.
// No dependencies.
package wpd_pkg;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_UNSUPP = 2'd2;
  localparam logic [1:0] ST_RAW_MISALIGN = 2'd3;
  localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] RIFF_WORD = 32'h4646_4952;
  localparam logic [31:0] WAVE_WORD = 32'h4556_4157;

  typedef struct packed {
    logic [7:0] data_byte;
    logic end_of_file;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic signed [31:0] sample;
    logic [1:0] status;
    logic last;
  } out_item_t;
endpackage

@@ hdl/wpd_in_if.sv @@
// Valid/ready channel interfaces for the PCM16 stream decoder.
// Depends on wpd_pkg.
interface wpd_in_if import wpd_pkg::*; ();
  logic valid;
  logic ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface wpd_out_if import wpd_pkg::*; ();
  logic valid;
  logic ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/wav_pcm16_stream_decoder_core.sv @@
// Top level: RIFF/WAVE PCM16 parser with raw int32 fallback.
// Frame averaging uses a restoring divider, one quotient bit a cycle.
// A closing frame runs the divider before its average is loaded into the output
// register; each result waits in an output register until transferred.
// Throughput: one byte per cycle outside frame ends and result delivery.
// Reset (rst, synchronous): parser returns to header phase, output empty.
`include "wav_pcm16_stream_decoder_core_defines.svh"
module wav_pcm16_stream_decoder_core import wpd_pkg::*; (
  input logic clk,
  input logic rst,
  wpd_in_if.sink in_ch,
  wpd_out_if.source out_ch
);
  typedef enum logic [2:0] {
    M_HEADER, M_CHDR, M_SKIP, M_FMT, M_DATA, M_PAD, M_RAW
  } mode_t;
  typedef enum logic [2:0] {
    S_IN, S_DIV, S_EMIT, S_HDR, S_STAT
  } seq_t;

  mode_t mode;
  seq_t seq;
  logic [7:0] hdr [12];
  logic [31:0] total_bytes, chunk_tag, chunk_length, chunk_offset;
  logic [15:0] format_code, channel_count, bits_seen, channel_index, lo_byte;
  logic format_seen, data_seen;
  logic [31:0] word_asm, channel_sum;
  logic eof_pend;
  logic [1:0] hdr_idx, hdr_cnt;
  logic [47:0] dividend;
  logic [16:0] rem;
  logic [5:0] div_cnt;
  logic div_neg;
  out_item_t res;
  logic res_valid;

  logic [7:0] b;
  logic [31:0] tb1, v16, sum_next, q32;
  logic [16:0] rem_sh;
  logic take, dec_en;

  assign b = in_ch.payload.data_byte;
  assign tb1 = total_bytes + 32'd1;
  assign dec_en = channel_count != 16'd0 && format_code == 16'd1 && bits_seen == 16'd16;
  assign v16 = {{16{b[7]}}, b, lo_byte[7:0]};
  assign sum_next = channel_sum + v16;
  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = seq == S_IN && !res_valid;
  assign out_ch.valid = res_valid;
  assign out_ch.payload = res;
  assign rem_sh = {rem[15:0], dividend[47]};
  assign q32 = div_neg ? (32'd0 - dividend[31:0]) : dividend[31:0];

  function automatic logic [31:0] hword(input logic [7:0] h [12], input logic [1:0] i);
    logic [3:0] base;
    base = {i, 2'b00};
    return {h[base + 4'd3], h[base + 4'd2], h[base + 4'd1], h[base]};
  endfunction

  function automatic logic [1:0] status_of(input mode_t m, input logic [31:0] tb,
      input logic ds, input logic [15:0] cc, input logic [15:0] fc, input logic [15:0] bs);
    if (m == M_HEADER || m == M_RAW) return (tb[1:0] != 2'd0) ? ST_RAW_MISALIGN : ST_OK;
    else if (!ds || cc == 16'd0) return ST_MISSING;
    else if (fc != 16'd1 || bs != 16'd16) return ST_UNSUPP;
    return ST_OK;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_HEADER; seq <= S_IN; res_valid <= 1'b0;
      total_bytes <= '0; chunk_tag <= '0; chunk_length <= '0; chunk_offset <= '0;
      format_code <= '0; channel_count <= '0; bits_seen <= '0;
      format_seen <= 1'b0; data_seen <= 1'b0; word_asm <= '0;
      channel_index <= '0; channel_sum <= '0; eof_pend <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      unique case (seq)
        S_IN: if (take) begin
          total_bytes <= tb1;
          eof_pend <= in_ch.payload.end_of_file;
          seq <= in_ch.payload.end_of_file ? S_STAT : S_IN;
          unique case (mode)
            M_HEADER: begin
              hdr[tb1[3:0] - 4'd1] <= b;
              hdr_idx <= 2'd0;
              if (tb1 == 32'd12 && {hdr[3], hdr[2], hdr[1], hdr[0]} == RIFF_WORD &&
                  {b, hdr[10], hdr[9], hdr[8]} == WAVE_WORD) begin
                mode <= M_CHDR; chunk_offset <= '0;
              end else if (tb1 == 32'd12) begin
                mode <= M_RAW; word_asm <= '0;
                hdr_cnt <= 2'd3; seq <= S_HDR;
              end else if (in_ch.payload.end_of_file) begin
                hdr_cnt <= tb1[3:2];
                seq <= (tb1[3:2] != 2'd0) ? S_HDR : S_STAT;
              end
            end
            M_CHDR: begin
              if (chunk_offset < 32'd4) chunk_tag <= {b, chunk_tag[31:8]};
              else chunk_length <= {b, chunk_length[31:8]};
              chunk_offset <= chunk_offset + 32'd1;
              if (chunk_offset == 32'd7) begin
                chunk_offset <= '0; channel_index <= '0; channel_sum <= '0;
                word_asm <= '0; chunk_tag <= '0;
                if (chunk_tag == TAG_FMT && !data_seen &&
                    {b, chunk_length[31:8]} >= 32'd16) mode <= M_FMT;
                else if (chunk_tag == TAG_DATA && !data_seen && format_seen) begin
                  mode <= ({b, chunk_length[31:8]} == 32'd0) ? M_CHDR : M_DATA;
                  data_seen <= 1'b1;
                end else mode <= ({b, chunk_length[31:8]} == 32'd0) ? M_CHDR : M_SKIP;
              end
            end
            M_PAD: begin
              mode <= M_CHDR; chunk_offset <= '0;
            end
            M_RAW: begin
              unique case (tb1[1:0] - 2'd1)
                2'd0: word_asm <= {24'd0, b};
                2'd1: word_asm[15:8] <= b;
                2'd2: word_asm[23:16] <= b;
                default: begin
                  res <= '{kind: 1'b0, sample: {b, word_asm[23:0]}, status: ST_OK,
                           last: 1'b0};
                  res_valid <= 1'b1; word_asm <= '0;
                  seq <= in_ch.payload.end_of_file ? S_EMIT : S_IN;
                end
              endcase
            end
            default: begin
              if (mode == M_FMT) begin
                if (chunk_offset < 32'd4) begin
                  case (chunk_offset[1:0])
                    2'd0: chunk_tag[7:0] <= chunk_tag[7:0] | b;
                    2'd1: chunk_tag[15:8] <= chunk_tag[15:8] | b;
                    2'd2: chunk_tag[23:16] <= chunk_tag[23:16] | b;
                    default: chunk_tag[31:24] <= chunk_tag[31:24] | b;
                  endcase
                end else if (chunk_offset == 32'd14) word_asm <= {24'd0, b};
                else if (chunk_offset == 32'd15) begin
                  format_code <= chunk_tag[15:0];
                  channel_count <= chunk_tag[31:16];
                  bits_seen <= {b, word_asm[7:0]};
                  format_seen <= 1'b1;
                end
              end else if (mode == M_DATA && dec_en) begin
                if (!chunk_offset[0]) lo_byte <= {8'd0, b};
                else if (channel_index + 16'd1 >= channel_count) begin
                  div_neg <= sum_next[31];
                  dividend <= {(sum_next[31] ? 32'd0 - sum_next : sum_next), 16'd0};
                  rem <= '0; div_cnt <= 6'd48; seq <= S_DIV;
                  channel_index <= '0; channel_sum <= '0;
                end else begin
                  channel_sum <= sum_next; channel_index <= channel_index + 16'd1;
                end
              end
              chunk_offset <= chunk_offset + 32'd1;
              if (chunk_offset + 32'd1 >= chunk_length) begin
                mode <= chunk_length[0] ? M_PAD : M_CHDR;
                chunk_offset <= '0; chunk_tag <= '0;
                channel_index <= '0; channel_sum <= '0;
              end
            end
          endcase
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, channel_count}) begin
            rem <= rem_sh - {1'b0, channel_count};
            dividend <= {dividend[46:0], 1'b1};
          end else begin
            rem <= rem_sh;
            dividend <= {dividend[46:0], 1'b0};
          end
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) seq <= S_EMIT;
        end
        S_EMIT: if (!res_valid) begin
          if (mode == M_RAW || mode == M_HEADER) begin
            seq <= eof_pend ? S_STAT : S_IN;
          end else begin
            res <= '{kind: 1'b0, sample: q32, status: ST_OK, last: 1'b0};
            res_valid <= 1'b1;
            seq <= eof_pend ? S_STAT : S_IN;
          end
        end
        S_HDR: if (!res_valid) begin
          res <= '{kind: 1'b0, sample: hword(hdr, hdr_idx), status: ST_OK, last: 1'b0};
          res_valid <= 1'b1;
          hdr_idx <= hdr_idx + 2'd1;
          if (hdr_idx + 2'd1 == hdr_cnt) seq <= eof_pend ? S_STAT : S_IN;
        end
        default: if (!res_valid) begin
          res <= '{kind: 1'b1, sample: 32'd0,
                   status: status_of(mode, total_bytes, data_seen, channel_count,
                                     format_code, bits_seen), last: 1'b1};
          res_valid <= 1'b1;
          seq <= S_IN; mode <= M_HEADER;
          total_bytes <= '0; chunk_tag <= '0; chunk_length <= '0; chunk_offset <= '0;
          format_code <= '0; channel_count <= '0; bits_seen <= '0;
          format_seen <= 1'b0; data_seen <= 1'b0; word_asm <= '0;
          channel_index <= '0; channel_sum <= '0; eof_pend <= 1'b0;
        end
      endcase
    end
  end

  `WPD_ASSERT_IMPL(a_ready_idle, clk, rst, in_ch.ready, seq == S_IN && !res_valid)
  `WPD_ASSERT_IMPL(a_last_kind, clk, rst, res_valid, res.last == res.kind)
  `WPD_ASSERT_NEXT(a_div_nonzero, clk, rst, seq == S_DIV, channel_count != 16'd0)
  `WPD_ASSERT_NEXT(a_stat_reset, clk, rst, seq == S_STAT && !res_valid,
                   mode == M_HEADER && total_bytes == 32'd0)
endmodule
